// ----- hw/rtl/mpsc_pkg.sv -----
// Package for the minimum perfect square count block.
// Holds the widths, step addresses, control word layout and microcode ROM.
// No dependencies.
`default_nettype none

package mpsc_pkg;

    localparam int MAX_TARGET_DEFAULT = 16383;
    localparam int TARGET_W = 14;
    localparam int COUNT_W = 3;
    localparam int STEP_W = 3;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT  = 3'd0;
    localparam step_t STEP_CHECK = 3'd1;
    localparam step_t STEP_SEED  = 3'd2;
    localparam step_t STEP_ROOT  = 3'd3;
    localparam step_t STEP_FILL  = 3'd4;
    localparam step_t STEP_OUT   = 3'd5;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_NO_INPUT,
        COND_SHORT_TARGET,
        COND_SEED_LAST,
        COND_ROOT_MORE,
        COND_ROW_LAST,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic  in_ready;
        logic  seed_write;
        logic  root_step;
        logic  fill_write;
        logic  res_short;
        logic  out_load;
        logic  row_init;
        cond_t cond;
        step_t jmp_addr;
        step_t next_addr;
    } ucode_t;

    typedef struct packed {
        logic no_input;
        logic short_target;
        logic seed_last;
        logic root_more;
        logic row_last;
        logic out_busy;
    } status_t;

    function automatic ucode_t ucode_rom(input step_t addr);
        ucode_t w;
        w = '0;
        w.cond = COND_NONE;
        unique case (addr)
            STEP_WAIT:
            begin
                w.in_ready  = 1'b1;
                w.cond      = COND_NO_INPUT;
                w.jmp_addr  = STEP_WAIT;
                w.next_addr = STEP_CHECK;
            end
            STEP_CHECK:
            begin
                w.res_short = 1'b1;
                w.cond      = COND_SHORT_TARGET;
                w.jmp_addr  = STEP_OUT;
                w.next_addr = STEP_SEED;
            end
            STEP_SEED:
            begin
                w.seed_write = 1'b1;
                w.row_init   = 1'b1;
                w.cond       = COND_SEED_LAST;
                w.jmp_addr   = STEP_ROOT;
                w.next_addr  = STEP_SEED;
            end
            STEP_ROOT:
            begin
                w.root_step = 1'b1;
                w.cond      = COND_ROOT_MORE;
                w.jmp_addr  = STEP_ROOT;
                w.next_addr = STEP_FILL;
            end
            STEP_FILL:
            begin
                w.fill_write = 1'b1;
                w.row_init   = 1'b1;
                w.cond       = COND_ROW_LAST;
                w.jmp_addr   = STEP_OUT;
                w.next_addr  = STEP_ROOT;
            end
            STEP_OUT:
            begin
                w.out_load  = 1'b1;
                w.cond      = COND_OUT_BUSY;
                w.jmp_addr  = STEP_OUT;
                w.next_addr = STEP_WAIT;
            end
            default:
            begin
                w.next_addr = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mpsc_seq.sv -----
// Microcode sequencer: step counter, control word ROM and conditional jumps.
// Depends on mpsc_pkg.
`default_nettype none

module mpsc_seq
    import mpsc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire status_t status,
    output ucode_t       ctrl
);

    step_t pc_reg;
    step_t pc_next;
    logic  taken;

    assign ctrl = ucode_rom(pc_reg);

    always_comb
    begin
        taken = 1'b0;
        unique case (ctrl.cond)
            COND_NONE:         taken = 1'b0;
            COND_NO_INPUT:     taken = status.no_input;
            COND_SHORT_TARGET: taken = status.short_target;
            COND_SEED_LAST:    taken = status.seed_last;
            COND_ROOT_MORE:    taken = status.root_more;
            COND_ROW_LAST:     taken = status.row_last;
            COND_OUT_BUSY:     taken = status.out_busy;
            default:           taken = 1'b0;
        endcase
        pc_next = taken ? ctrl.jmp_addr : ctrl.next_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mpsc_dp.sv -----
// Datapath: target, row and root registers, the count table memory and the output register.
// Driven by control words from mpsc_seq. Depends on mpsc_pkg.
`default_nettype none

module mpsc_dp
    import mpsc_pkg::*;
#(
    parameter int MAX_TARGET = MAX_TARGET_DEFAULT
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ucode_t              ctrl,
    output status_t                  status,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [TARGET_W-1:0] target,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [COUNT_W-1:0]       square_count
);

    localparam int DEPTH  = MAX_TARGET + 1;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int ROOT_W = (IDX_W + 1) / 2;
    localparam int X_W    = ROOT_W + 1;
    localparam int SQ_W   = IDX_W + 2;
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_TARGET);

    logic [COUNT_W-1:0] table_mem [DEPTH];

    logic [IDX_W-1:0]   t_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [X_W-1:0]     x_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [COUNT_W-1:0] best_reg;
    logic [COUNT_W-1:0] res_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] rd_data_reg;
    logic               pend_reg;
    logic               out_valid_reg;

    logic               fire;
    logic               out_busy;
    logic [IDX_W-1:0]   t_sat;
    logic [COUNT_W:0]   cand_wide;
    logic [COUNT_W-1:0] cand;
    logic [COUNT_W-1:0] best_next;
    logic [SQ_W-1:0]    sq_step;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [COUNT_W-1:0] wr_data;

    assign in_ready     = ctrl.in_ready;
    assign fire         = in_valid & ctrl.in_ready;
    assign out_valid    = out_valid_reg;
    assign square_count = count_reg;
    assign out_busy     = out_valid_reg & ~out_ready;

    assign t_sat     = (32'(target) > 32'(MAX_TARGET)) ? MAX_IDX : IDX_W'(target);
    assign cand_wide = {1'b0, rd_data_reg} + {{COUNT_W{1'b0}}, 1'b1};
    assign cand      = cand_wide[COUNT_W] ? {COUNT_W{1'b1}} : cand_wide[COUNT_W-1:0];
    assign best_next = (pend_reg && (cand < best_reg)) ? cand : best_reg;
    assign sq_step   = sq_reg + SQ_W'({x_reg, 1'b1});
    assign rd_addr   = IDX_W'(SQ_W'(i_reg) - sq_reg);
    assign wr_en     = ctrl.seed_write | ctrl.fill_write;
    assign wr_data   = ctrl.seed_write ? COUNT_W'(i_reg) : best_next;

    assign status.no_input     = ~in_valid;
    assign status.short_target = (32'(t_reg) <= 32'd3);
    assign status.seed_last    = (32'(i_reg) == 32'd3);
    assign status.root_more    = (sq_step <= SQ_W'(i_reg));
    assign status.row_last     = (i_reg == t_reg);
    assign status.out_busy     = out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            if (ctrl.out_load && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ctrl.row_init)
            begin
                pend_reg <= 1'b0;
            end
            else if (ctrl.root_step)
            begin
                pend_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            t_reg <= t_sat;
            i_reg <= '0;
        end
        else if (wr_en)
        begin
            i_reg <= i_reg + IDX_W'(1);
        end
        if (ctrl.row_init)
        begin
            x_reg    <= X_W'(1);
            sq_reg   <= SQ_W'(1);
            best_reg <= {COUNT_W{1'b1}};
        end
        else if (ctrl.root_step)
        begin
            x_reg    <= x_reg + X_W'(1);
            sq_reg   <= sq_step;
            best_reg <= best_next;
        end
        if (ctrl.res_short)
        begin
            res_reg <= t_reg[COUNT_W-1:0];
        end
        else if (ctrl.fill_write)
        begin
            res_reg <= best_next;
        end
        if (ctrl.out_load && !out_busy)
        begin
            count_reg <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[i_reg] <= wr_data;
        end
        if (ctrl.root_step)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/min_perfect_square_count_top.sv -----
// Top level of the minimum perfect square count block.
// Instantiates mpsc_seq and mpsc_dp; depends on mpsc_pkg.
`default_nettype none

// Each target word yields one count word: the fewest perfect squares that sum to it.
// Targets above MAX_TARGET are clamped to it, and targets 0 to 3 return themselves
// without a table build. A larger target t rebuilds a 3-bit count table
// from entry 0 up to t: it seeds entries 0 to 3, then for each row reads one entry
// per root through the single table read port, which serves one root per cycle, and
// then writes the row. The block takes one target at a time; a new target is taken
// while the previous count still waits at the output. The table needs no clearing
// after reset.
module min_perfect_square_count_top
    import mpsc_pkg::*;
#(
    parameter int MAX_TARGET = MAX_TARGET_DEFAULT
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [TARGET_W-1:0] target,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [COUNT_W-1:0]       square_count
);

    ucode_t  ctrl;
    status_t status;

    mpsc_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    mpsc_dp #(
        .MAX_TARGET (MAX_TARGET)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .target       (target),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .square_count (square_count)
    );

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("A second word was taken while a target was in progress.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (square_count <= 3'd4))
        else $error("The output count exceeds four.");

    a_fill_after_root: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.fill_write |-> $past(ctrl.root_step))
        else $error("A table row was written without a preceding root read.");
`endif

endmodule

`default_nettype wire
